### src/ghb_pkg.sv
// ----------------------------------------------------------------------------
// ghb_pkg
// Shared constants, types and the falloff table of the height brush.
// ----------------------------------------------------------------------------
package ghb_pkg;

    localparam int GRID_SIZE        = 64;
    localparam int MAX_RADIUS       = 15;
    localparam int GAUSS_TABLE_SIZE = 64;
    localparam int HEIGHT_OFFSET    = 2560;

    localparam int CW      = $clog2(GRID_SIZE);
    localparam int CELLS   = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int DATA_W  = 24;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 2);
    localparam int DD_W    = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 2);
    localparam int N_W     = DD_W + 32;
    localparam int CMP_W   = (N_W > 36) ? N_W : 36;
    localparam int Q_W     = $clog2(GAUSS_TABLE_SIZE);
    localparam int DIV_W   = 38 + Q_W;
    localparam int DCNT_W  = $clog2(Q_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_UNIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_CODE   = 3'd5;

    typedef enum logic [1:0] {
        OP_BRUSH_DELTA = 2'd0,
        OP_BRUSH_ABS   = 2'd1,
        OP_WRITE_CELL  = 2'd2,
        OP_READ_CELL   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RAW_WR, S_RD, S_RD_CAP,
        S_CTR_RD, S_CTR_CAP, S_SETUP, S_WIN, S_DIST0, S_DIST1,
        S_CHK, S_DIV, S_OFF, S_WR
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic raw_wr;
        logic rd_cap;
        logic ctr_cap;
        logic setup;
        logic win;
        logic dist0;
        logic dist1;
        logic chk;
        logic div_step;
        logic off;
        logic wr_cell;
        logic cell_next;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic    clr_last;
        t_opcode op;
        logic    in_circle;
        logic    div_last;
        logic    last_cell;
    } t_dp_stat;

    typedef logic [15:0] t_falloff [GAUSS_TABLE_SIZE];

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 1 - exp(-4.5*i/(N-1)) in Q0.16, built with Q30 series arithmetic.
    function automatic t_falloff build_falloff();
        t_falloff    tab;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] ey;
        logic [63:0] r;
        logic [63:0] comp;
        logic [63:0] q;
        for (int i = 0; i < GAUSS_TABLE_SIZE; i++) begin
            x  = udiv64((64'd9 << 29) * 64'(i), 64'(GAUSS_TABLE_SIZE - 1));
            y  = x >> 3;
            t  = 64'd1 << 30;
            ey = 64'd1 << 30;
            for (int n = 1; n <= 20; n++) begin
                t  = udiv64((t * y) >> 30, 64'(n));
                ey = ey + t;
            end
            r = udiv64(64'd1 << 60, ey);
            for (int k = 0; k < 3; k++) begin
                r = (r * r) >> 30;
            end
            if (r > (64'd1 << 30)) begin
                r = 64'd1 << 30;
            end
            comp = (64'd1 << 30) - r;
            q    = (comp + (64'd1 << 13)) >> 14;
            if (q > 64'd65535) begin
                q = 64'd65535;
            end
            tab[i] = 16'(q);
        end
        return tab;
    endfunction

    localparam t_falloff FALLOFF = build_falloff();

endpackage

### src/ghb_ram.sv
// ----------------------------------------------------------------------------
// ghb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ghb_ctrl.sv
// ----------------------------------------------------------------------------
// ghb_ctrl
// Sequencer of the height brush: clear pass, raw access and the cell loop.
// ----------------------------------------------------------------------------
module ghb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ghb_pkg::t_dp_stat i_stat,
    output ghb_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    import ghb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_WRITE_CELL: n_state = S_RAW_WR;
                    OP_READ_CELL:  n_state = S_RD;
                    default:       n_state = S_CTR_RD;
                endcase
            end
            S_RAW_WR: begin
                o_cmd.raw_wr = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                n_state = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.rd_cap = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            S_CTR_RD: begin
                n_state = S_CTR_CAP;
            end
            S_CTR_CAP: begin
                o_cmd.ctr_cap = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_WIN;
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
                n_state = S_DIST0;
            end
            S_DIST0: begin
                o_cmd.dist0 = 1'b1;
                n_state = S_DIST1;
            end
            S_DIST1: begin
                o_cmd.dist1 = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_stat.in_circle) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.cell_next = 1'b1;
                    if (i_stat.last_cell) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DIST0;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                o_cmd.off = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_cell   = 1'b1;
                o_cmd.cell_next = 1'b1;
                if (i_stat.last_cell) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIST0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### src/ghb_datapath.sv
// ----------------------------------------------------------------------------
// ghb_datapath
// Registers, grid memory and arithmetic of the height brush.
// ----------------------------------------------------------------------------
module ghb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ghb_pkg::t_ctl_cmd                   i_cmd,
    output ghb_pkg::t_dp_stat                   o_stat,
    input  logic                                i_cfg_we,
    input  logic [ghb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ghb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [1:0]                          i_opcode,
    input  logic [5:0]                          i_cell_row,
    input  logic [5:0]                          i_cell_column,
    input  logic signed [15:0]                  i_amount,
    input  logic                                i_paint_element,
    input  logic [7:0]                          i_element_in,
    output logic signed [15:0]                  o_applied_height,
    output logic [5:0]                          o_box_row_min,
    output logic [5:0]                          o_box_row_max,
    output logic [5:0]                          o_box_col_min,
    output logic [5:0]                          o_box_col_max,
    output logic signed [15:0]                  o_cell_height,
    output logic [7:0]                          o_cell_element
);

    import ghb_pkg::*;

    // Configuration.
    logic signed [15:0] r_min_h;
    logic signed [15:0] r_max_h;
    logic [15:0]        r_sigma;
    logic [15:0]        r_spacing;
    logic [15:0]        r_cpu;
    logic [7:0]         r_elem_code;

    // Item.
    t_opcode            r_op;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic signed [15:0] r_amount;
    logic               r_paint;
    logic [7:0]         r_elem_in;

    // Brush setup.
    logic signed [15:0] r_centre;
    logic signed [15:0] r_value;
    logic [31:0]        r_s2;
    logic [31:0]        r_sp2;
    logic [31:0]        r_sc;
    logic               r_up;
    logic [16:0]        r_scale;
    logic [RAD_W-1:0]   r_rad;
    logic [35:0]        r_9s2;
    logic [36:0]        r_d18;
    logic [CW-1:0]      r_rmin;
    logic [CW-1:0]      r_rmax;
    logic [CW-1:0]      r_cmin;
    logic [CW-1:0]      r_cmax;

    // Cell loop.
    logic [CW-1:0]      r_r;
    logic [CW-1:0]      r_c;
    logic [DD_W-1:0]    r_dd;
    logic [N_W-1:0]     r_n;
    logic signed [15:0] r_q_h;
    logic [7:0]         r_q_e;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_dsh;
    logic [Q_W-1:0]     r_q;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [16:0]        r_off;

    logic [ADDR_W-1:0]  r_clr_addr;

    // Memory port.
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    logic [ADDR_W-1:0]  ctr_addr;
    logic [ADDR_W-1:0]  cell_addr;
    logic signed [15:0] rd_h;
    logic [15:0]        sg;
    logic signed [16:0] v_raw;
    logic signed [16:0] v_lo;
    logic signed [16:0] v_clamped;
    logic signed [16:0] range_s;
    logic [16:0]        range_abs;
    logic [34:0]        rad_sum;
    logic [18:0]        rad_full;
    int                 win_rmin;
    int                 win_rmax;
    int                 win_cmin;
    int                 win_cmax;
    logic signed [CW:0] dr;
    logic signed [CW:0] dc;
    logic signed [2*CW+1:0] dr_x;
    logic signed [2*CW+1:0] dc_x;
    logic [2*CW+1:0]    dr2;
    logic [2*CW+1:0]    dc2;
    logic               in_circle;
    logic [DIV_W-1:0]   div_num;
    logic               div_ge;
    logic [Q_W-1:0]     idx;
    logic [32:0]        off_prod;
    logic signed [18:0] nv_w;
    logic signed [15:0] nv;
    logic               moves_up;

    ghb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign ctr_addr  = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(GRID_SIZE) + ADDR_W'(r_col));
    assign cell_addr = ADDR_W'(ADDR_W'(r_r) * ADDR_W'(GRID_SIZE) + ADDR_W'(r_c));
    assign mem_raddr = i_cmd.dist0 ? cell_addr : ctr_addr;
    assign rd_h      = $signed(mem_rdata[DATA_W-1:8]);

    // Centre target: delta is formed at full width, then the lower clamp and
    // the upper clamp, so max_height wins over an inverted pair.
    assign sg        = (r_sigma == 16'd0) ? 16'd1 : r_sigma;
    assign v_raw     = (r_op == OP_BRUSH_DELTA) ? (17'(rd_h) + 17'(r_amount)) : 17'(r_amount);
    assign v_lo      = (v_raw < 17'(r_min_h)) ? 17'(r_min_h) : v_raw;
    assign v_clamped = (v_lo > 17'(r_max_h)) ? 17'(r_max_h) : v_lo;

    assign range_s   = 17'(r_max_h) - 17'(r_min_h);
    assign range_abs = (range_s < 0) ? 17'(-range_s) : 17'(range_s);
    assign rad_sum   = 35'({r_sc, 1'b0}) + 35'(r_sc) + 35'd65535;
    assign rad_full  = rad_sum[34:16];

    assign win_rmin = (int'(r_row) > int'(r_rad)) ? int'(r_row) - int'(r_rad) : 0;
    assign win_cmin = (int'(r_col) > int'(r_rad)) ? int'(r_col) - int'(r_rad) : 0;
    assign win_rmax = (int'(r_row) + int'(r_rad) > GRID_SIZE - 1) ?
                      GRID_SIZE - 1 : int'(r_row) + int'(r_rad);
    assign win_cmax = (int'(r_col) + int'(r_rad) > GRID_SIZE - 1) ?
                      GRID_SIZE - 1 : int'(r_col) + int'(r_rad);

    assign dr   = $signed({1'b0, r_r}) - $signed({1'b0, r_row});
    assign dc   = $signed({1'b0, r_c}) - $signed({1'b0, r_col});
    assign dr_x = (2*CW+2)'(dr);
    assign dc_x = (2*CW+2)'(dc);
    assign dr2  = $unsigned(dr_x * dr_x);
    assign dc2  = $unsigned(dc_x * dc_x);

    assign in_circle = (CMP_W'(r_n) <= CMP_W'(r_9s2));
    assign div_num = DIV_W'(r_n) * DIV_W'(2 * (GAUSS_TABLE_SIZE - 1)) + DIV_W'(r_9s2);
    assign div_ge  = (r_rem >= r_dsh);

    assign idx      = (int'(r_q) > GAUSS_TABLE_SIZE - 1) ?
                      Q_W'(GAUSS_TABLE_SIZE - 1) : r_q;
    assign off_prod = 33'(r_scale) * 33'(FALLOFF[idx]) + 33'd32768;

    assign nv_w = r_up ? (19'(r_value) - $signed({2'b00, r_off}))
                       : (19'(r_value) + $signed({2'b00, r_off}));
    assign nv   = (nv_w < -19'sd32768) ? -16'sd32768 :
                  (nv_w >  19'sd32767) ?  16'sd32767 : 16'(nv_w);
    assign moves_up = (nv > r_q_h);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ctr_addr;
        mem_wdata = {r_amount, r_elem_in};
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.raw_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.wr_cell) begin
            mem_we    = (moves_up == r_up);
            mem_waddr = cell_addr;
            mem_wdata = {nv, r_paint ? r_elem_code : r_q_e};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_h     <= -16'sd32768;
            r_max_h     <= 16'sd32767;
            r_sigma     <= 16'd256;
            r_spacing   <= 16'd256;
            r_cpu       <= 16'd256;
            r_elem_code <= 8'd0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_HEIGHT:     r_min_h     <= $signed(i_cfg_wdata);
                    CFG_MAX_HEIGHT:     r_max_h     <= $signed(i_cfg_wdata);
                    CFG_SIGMA:          r_sigma     <= i_cfg_wdata;
                    CFG_CELL_SPACING:   r_spacing   <= i_cfg_wdata;
                    CFG_CELLS_PER_UNIT: r_cpu       <= i_cfg_wdata;
                    CFG_ELEMENT_CODE:   r_elem_code <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op      <= t_opcode'(i_opcode);
            r_row     <= (int'(i_cell_row) > GRID_SIZE - 1) ?
                         CW'(GRID_SIZE - 1) : CW'(i_cell_row);
            r_col     <= (int'(i_cell_column) > GRID_SIZE - 1) ?
                         CW'(GRID_SIZE - 1) : CW'(i_cell_column);
            r_amount  <= i_amount;
            r_paint   <= i_paint_element;
            r_elem_in <= i_element_in;
        end
        if (i_cmd.ctr_cap) begin
            r_centre <= rd_h;
            r_value  <= 16'(v_clamped);
            r_s2     <= 32'(sg) * 32'(sg);
            r_sp2    <= 32'(r_spacing) * 32'(r_spacing);
            r_sc     <= 32'(sg) * 32'(r_cpu);
        end
        if (i_cmd.setup) begin
            r_up    <= (r_value > r_centre);
            r_scale <= range_abs + 17'(HEIGHT_OFFSET);
            r_rad   <= (rad_full > 19'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_full);
            r_9s2   <= {r_s2, 3'b000} + 36'(r_s2);
            r_d18   <= {{r_s2, 3'b000} + 36'(r_s2), 1'b0};
        end
        if (i_cmd.win) begin
            r_rmin <= CW'(win_rmin);
            r_rmax <= CW'(win_rmax);
            r_cmin <= CW'(win_cmin);
            r_cmax <= CW'(win_cmax);
            r_r    <= CW'(win_rmin);
            r_c    <= CW'(win_cmin);
        end
        if (i_cmd.dist0) begin
            r_dd <= DD_W'(dr2 + dc2);
        end
        if (i_cmd.dist1) begin
            r_n   <= N_W'(r_dd) * N_W'(r_sp2);
        end
        if (i_cmd.dist1 || i_cmd.rd_cap) begin
            r_q_h <= rd_h;
            r_q_e <= mem_rdata[7:0];
        end
        if (i_cmd.chk) begin
            r_rem  <= div_num;
            r_dsh  <= DIV_W'(r_d18) << (Q_W - 1);
            r_q    <= '0;
            r_dcnt <= '0;
        end
        // Restoring division, one quotient bit per cycle.
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_q    <= Q_W'({r_q, div_ge});
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.off) begin
            r_off <= off_prod[32:16];
        end
        if (i_cmd.cell_next) begin
            if (r_c == r_cmax) begin
                r_c <= r_cmin;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
        if (i_cmd.finish) begin
            case (r_op)
                OP_WRITE_CELL: begin
                    o_applied_height <= r_amount;
                    o_cell_height    <= r_amount;
                    o_cell_element   <= r_elem_in;
                    o_box_row_min    <= 6'(r_row);
                    o_box_row_max    <= 6'(r_row);
                    o_box_col_min    <= 6'(r_col);
                    o_box_col_max    <= 6'(r_col);
                end
                OP_READ_CELL: begin
                    o_applied_height <= '0;
                    o_cell_height    <= rd_h;
                    o_cell_element   <= mem_rdata[7:0];
                    o_box_row_min    <= 6'(r_row);
                    o_box_row_max    <= 6'(r_row);
                    o_box_col_min    <= 6'(r_col);
                    o_box_col_max    <= 6'(r_col);
                end
                default: begin
                    o_applied_height <= r_value;
                    o_cell_height    <= '0;
                    o_cell_element   <= '0;
                    o_box_row_min    <= 6'(r_rmin);
                    o_box_row_max    <= 6'(r_rmax);
                    o_box_col_min    <= 6'(r_cmin);
                    o_box_col_max    <= 6'(r_cmax);
                end
            endcase
        end
    end

    assign o_stat.clr_last  = (r_clr_addr == ADDR_W'(CELLS - 1));
    assign o_stat.op        = r_op;
    assign o_stat.in_circle = in_circle;
    assign o_stat.div_last  = (r_dcnt == DCNT_W'(Q_W - 1));
    assign o_stat.last_cell = (r_r == r_rmax) && (r_c == r_cmax);

endmodule

### src/gaussian_height_brush.sv
// ----------------------------------------------------------------------------
// gaussian_height_brush
// Gaussian brush over a 64 x 64 height grid with an element-code grid.
// ----------------------------------------------------------------------------
// After reset the block clears both grids, one cell per cycle, and holds busy
// high for the whole clear pass. An item is taken when start is high and busy is
// low; its single result appears for one cycle with o_done, and the receiver
// cannot hold it off. A raw write passes through decode and the write state, a
// raw read through decode, the read state and the capture state. A brush walks
// its window one cell at a time through the single grid memory, after the centre
// read, setup and window states: each cell passes the distance states and the
// circle check, and one inside the circle also takes its table index from a
// restoring divider that yields one bit per cycle, then the offset and write.
// ----------------------------------------------------------------------------
module gaussian_height_brush (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic [5:0]                     i_cell_row,
    input  logic [5:0]                     i_cell_column,
    input  logic signed [15:0]             i_amount,
    input  logic                           i_paint_element,
    input  logic [7:0]                     i_element_in,
    input  logic                           i_cfg_we,
    input  logic [ghb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ghb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_done,
    output logic signed [15:0]             o_applied_height,
    output logic [5:0]                     o_box_row_min,
    output logic [5:0]                     o_box_row_max,
    output logic [5:0]                     o_box_col_min,
    output logic [5:0]                     o_box_col_max,
    output logic signed [15:0]             o_cell_height,
    output logic [7:0]                     o_cell_element
);

    import ghb_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    ghb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ghb_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_cell_row       (i_cell_row),
        .i_cell_column    (i_cell_column),
        .i_amount         (i_amount),
        .i_paint_element  (i_paint_element),
        .i_element_in     (i_element_in),
        .o_applied_height (o_applied_height),
        .o_box_row_min    (o_box_row_min),
        .o_box_row_max    (o_box_row_max),
        .o_box_col_min    (o_box_col_min),
        .o_box_col_max    (o_box_col_max),
        .o_cell_height    (o_cell_height),
        .o_cell_element   (o_cell_element)
    );

    // A result is only presented once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Every result closes a transaction that kept the block busy.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // The affected window is never inverted.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_box_row_min <= o_box_row_max) && (o_box_col_min <= o_box_col_max))
        else $error("inverted window");

    // A result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gaussian height brush. A predictor keeps its own
// height and element grids, so every result of a brush, raw write or raw read
// is checked field by field, across several register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghb_pkg::*;

    typedef struct {
        logic [15:0] applied;
        logic [5:0]  rmin;
        logic [5:0]  rmax;
        logic [5:0]  cmin;
        logic [5:0]  cmax;
        logic [15:0] height;
        logic [7:0]  element;
    } t_brush_result;

    class brush_scoreboard;
        int                    errors;
        t_brush_result         pending_results[$];
        shortint               heights[GRID_SIZE*GRID_SIZE];
        byte unsigned          elements[GRID_SIZE*GRID_SIZE];
        logic [15:0]           ramp[GAUSS_TABLE_SIZE];
        int                    lo_limit;
        int                    hi_limit;
        longint unsigned       sig_reg;
        longint unsigned       spacing_reg;
        longint unsigned       cpu_reg;
        byte unsigned          code_reg;

        function new();
            longint unsigned x, y, t, ey, r, q;
            errors = 0;
            lo_limit = -32768;
            hi_limit = 32767;
            sig_reg = 256;
            spacing_reg = 256;
            cpu_reg = 256;
            code_reg = 0;
            foreach (heights[k]) begin
                heights[k] = 0;
                elements[k] = 0;
            end
            // Falloff 1 - exp(-4.5*i/(N-1)) in Q0.16 via a Q30 series.
            for (int i = 0; i < GAUSS_TABLE_SIZE; i++) begin
                x = (64'd9 << 29) * i / (GAUSS_TABLE_SIZE - 1);
                y = x >> 3;
                t = 64'd1 << 30;
                ey = 64'd1 << 30;
                for (int n = 1; n <= 20; n++) begin
                    t = ((t * y) >> 30) / n;
                    ey += t;
                end
                r = (64'd1 << 60) / ey;
                repeat (3) r = (r * r) >> 30;
                if (r > (64'd1 << 30)) r = 64'd1 << 30;
                q = ((64'd1 << 30) - r + (64'd1 << 13)) >> 14;
                if (q > 65535) q = 65535;
                ramp[i] = q[15:0];
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MIN_HEIGHT:     lo_limit = $signed(data);
                CFG_MAX_HEIGHT:     hi_limit = $signed(data);
                CFG_SIGMA:          sig_reg = data;
                CFG_CELL_SPACING:   spacing_reg = data;
                CFG_CELLS_PER_UNIT: cpu_reg = data;
                CFG_ELEMENT_CODE:   code_reg = data[7:0];
                default: ;
            endcase
        endfunction

        function int clip_cell(int v);
            if (v < 0) return 0;
            if (v > GRID_SIZE - 1) return GRID_SIZE - 1;
            return v;
        endfunction

        function void note_item(t_opcode op, int row, int col, int amount, bit paint,
                                byte unsigned elem);
            t_brush_result   res;
            int              ctr, centre, target, span, scale, rad, nv;
            longint unsigned sg, s2, sp2, n, idx, off;
            bit              up;
            ctr = row * GRID_SIZE + col;
            res.applied = 0;
            res.height = 0;
            res.element = 0;
            res.rmin = row;
            res.rmax = row;
            res.cmin = col;
            res.cmax = col;
            if (op == OP_WRITE_CELL) begin
                heights[ctr] = amount;
                elements[ctr] = elem;
                res.applied = amount;
                res.height = amount;
                res.element = elem;
            end else if (op == OP_READ_CELL) begin
                res.height = heights[ctr];
                res.element = elements[ctr];
            end else begin
                centre = heights[ctr];
                target = (op == OP_BRUSH_DELTA) ? centre + amount : amount;
                sg = (sig_reg != 0) ? sig_reg : 1;
                s2 = sg * sg;
                sp2 = spacing_reg * spacing_reg;
                rad = int'((3 * sg * cpu_reg + 65535) >> 16 > MAX_RADIUS ? MAX_RADIUS
                           : (3 * sg * cpu_reg + 65535) >> 16);
                if (target < lo_limit) target = lo_limit;
                if (target > hi_limit) target = hi_limit;
                up = target > centre;
                span = hi_limit - lo_limit;
                if (span < 0) span = -span;
                scale = span + HEIGHT_OFFSET;
                res.rmin = clip_cell(row - rad);
                res.rmax = clip_cell(row + rad);
                res.cmin = clip_cell(col - rad);
                res.cmax = clip_cell(col + rad);
                for (int r = res.rmin; r <= res.rmax; r++) begin
                    for (int c = res.cmin; c <= res.cmax; c++) begin
                        n = longint'((r - row) * (r - row) + (c - col) * (c - col)) * sp2;
                        if (n <= 9 * s2) begin
                            idx = (n * (GAUSS_TABLE_SIZE - 1) * 2 + 9 * s2) / (18 * s2);
                            if (idx > GAUSS_TABLE_SIZE - 1) idx = GAUSS_TABLE_SIZE - 1;
                            off = (longint'(scale) * ramp[idx] + 32768) >> 16;
                            nv = up ? target - int'(off) : target + int'(off);
                            if (nv < -32768) nv = -32768;
                            if (nv > 32767) nv = 32767;
                            if ((nv > heights[r*GRID_SIZE+c]) == up) begin
                                heights[r*GRID_SIZE+c] = nv;
                                if (paint) elements[r*GRID_SIZE+c] = code_reg;
                            end
                        end
                    end
                end
                res.applied = target;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(t_brush_result got);
            t_brush_result exp_r;
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.applied !== exp_r.applied) begin
                $error("applied_height: expected %0h actual %0h", exp_r.applied, got.applied);
                errors++;
            end
            if (got.rmin !== exp_r.rmin) begin
                $error("box_row_min: expected %0d actual %0d", exp_r.rmin, got.rmin);
                errors++;
            end
            if (got.rmax !== exp_r.rmax) begin
                $error("box_row_max: expected %0d actual %0d", exp_r.rmax, got.rmax);
                errors++;
            end
            if (got.cmin !== exp_r.cmin) begin
                $error("box_col_min: expected %0d actual %0d", exp_r.cmin, got.cmin);
                errors++;
            end
            if (got.cmax !== exp_r.cmax) begin
                $error("box_col_max: expected %0d actual %0d", exp_r.cmax, got.cmax);
                errors++;
            end
            if (got.height !== exp_r.height) begin
                $error("cell_height: expected %0h actual %0h", exp_r.height, got.height);
                errors++;
            end
            if (got.element !== exp_r.element) begin
                $error("cell_element: expected %0h actual %0h", exp_r.element, got.element);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_opcode;
    logic [5:0]            i_cell_row;
    logic [5:0]            i_cell_column;
    logic signed [15:0]    i_amount;
    logic                  i_paint_element;
    logic [7:0]            i_element_in;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_done;
    logic signed [15:0]    o_applied_height;
    logic [5:0]            o_box_row_min;
    logic [5:0]            o_box_row_max;
    logic [5:0]            o_box_col_min;
    logic [5:0]            o_box_col_max;
    logic signed [15:0]    o_cell_height;
    logic [7:0]            o_cell_element;

    brush_scoreboard height_sb = new();

    gaussian_height_brush dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        t_brush_result got;
        if (i_rst_n && o_done) begin
            got.applied = o_applied_height;
            got.rmin = o_box_row_min;
            got.rmax = o_box_row_max;
            got.cmin = o_box_col_min;
            got.cmax = o_box_col_max;
            got.height = o_cell_height;
            got.element = o_cell_element;
            height_sb.check_result(got);
        end
    end

    initial begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Waits until the block has drained, then rewrites all six registers.
    task automatic set_registers(logic [15:0] lo, logic [15:0] hi, logic [15:0] sig,
                                 logic [15:0] spacing, logic [15:0] cpu, logic [7:0] code);
        logic [15:0] vals[6];
        vals = '{lo, hi, sig, spacing, cpu, {8'd0, code}};
        start <= 1'b0;
        while (height_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= k[CFG_IDX_W-1:0];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            height_sb.write_reg(k[CFG_IDX_W-1:0], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic issue(t_opcode op, int row, int col, logic [15:0] amount, bit paint,
                         logic [7:0] elem, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_cell_row <= row;
        i_cell_column <= col;
        i_amount <= amount;
        i_paint_element <= paint;
        i_element_in <= elem;
        do @(posedge i_clk); while (busy !== 1'b0);
        height_sb.note_item(op, row, col, $signed(amount), paint, elem);
    endtask

    task automatic random_item(bit wide);
        t_opcode op;
        int      pick;
        pick = $urandom_range(0, 99);
        if (wide) op = (pick < 8) ? t_opcode'($urandom_range(0, 1))
                                  : t_opcode'($urandom_range(2, 3));
        else op = t_opcode'(pick < 50 ? $urandom_range(0, 1) : $urandom_range(2, 3));
        issue(op, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
              $urandom_range(0, 1), $urandom, $urandom_range(0, 18));
    endtask

    initial begin
        bit wide;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_opcode <= OP_READ_CELL;
        i_cell_row <= '0;
        i_cell_column <= '0;
        i_amount <= '0;
        i_paint_element <= 1'b0;
        i_element_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The grid clear after reset keeps busy high for a while.
        do @(posedge i_clk); while (busy !== 1'b0);

        // Directed: reset settings, raw cell extremes and brush corner cases.
        issue(OP_READ_CELL, 63, 63, 16'h0000, 1'b0, 8'h00, 0);
        issue(OP_WRITE_CELL, 0, 0, 16'h7FFF, 1'b0, 8'hFF, 0);
        issue(OP_READ_CELL, 0, 0, 16'h0000, 1'b0, 8'h00, 2);
        issue(OP_WRITE_CELL, 63, 63, 16'h8000, 1'b1, 8'h00, 0);
        issue(OP_BRUSH_DELTA, 0, 0, 16'h7FFF, 1'b1, 8'h00, 1);
        issue(OP_BRUSH_DELTA, 63, 63, 16'h8000, 1'b0, 8'h00, 0);
        issue(OP_BRUSH_DELTA, 32, 32, 16'h0000, 1'b1, 8'h00, 0);
        issue(OP_BRUSH_ABS, 20, 40, 16'h1234, 1'b1, 8'h00, 3);
        issue(OP_READ_CELL, 20, 41, 16'h0000, 1'b0, 8'h00, 0);
        set_registers(16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'h0100, 8'hA5);
        issue(OP_BRUSH_ABS, 10, 10, 16'h7FFF, 1'b1, 8'h00, 0);
        issue(OP_BRUSH_DELTA, 10, 10, 16'h8000, 1'b1, 8'h00, 0);
        issue(OP_READ_CELL, 10, 10, 16'h0000, 1'b0, 8'h00, 0);
        set_registers(16'hF000, 16'h1000, 16'h0040, 16'h0000, 16'h0400, 8'h5A);
        issue(OP_BRUSH_ABS, 5, 60, 16'h0800, 1'b1, 8'h00, 0);
        issue(OP_READ_CELL, 5, 61, 16'h0000, 1'b0, 8'h00, 0);
        set_registers(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        issue(OP_BRUSH_ABS, 31, 31, 16'h4000, 1'b1, 8'h00, 0);
        set_registers(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'hFFFF, 8'h0F);
        issue(OP_BRUSH_DELTA, 40, 20, 16'hC000, 1'b1, 8'h00, 0);
        issue(OP_READ_CELL, 45, 25, 16'h0000, 1'b0, 8'h00, 0);

        // Random phases; most keep the radius small, a few use the largest window.
        for (int phase = 0; phase < 12; phase++) begin
            wide = (phase % 5 == 4);
            if (wide)
                set_registers($urandom, $urandom, 16'hFFFF, $urandom_range(1, 65535),
                              16'hFFFF, $urandom);
            else if ($urandom_range(0, 3) == 0)
                set_registers(16'h8000 + $urandom_range(0, 4000), 16'h7FFF - $urandom_range(0, 4000),
                              $urandom_range(0, 300), $urandom, $urandom_range(1, 300),
                              $urandom);
            else
                set_registers($urandom, $urandom, $urandom_range(1, 300), $urandom,
                              $urandom_range(1, 300), $urandom);
            for (int k = 0; k < 45; k++) random_item(wide);
            // Back-to-back stretch with no gaps.
            repeat (2) issue(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom, $urandom_range(0, 1),
                             $urandom, 0);
        end
        start <= 1'b0;

        while (height_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (height_sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### files.f
src/ghb_pkg.sv
src/ghb_ram.sv
src/ghb_ctrl.sv
src/ghb_datapath.sv
src/gaussian_height_brush.sv
bench/tb.sv
